/* rtl/pst_pkg.sv */
// Shared types and constants of the point set table.
`default_nettype none

package pst_pkg;

    localparam int OPCODE_W = 2;
    localparam int PCOUNT_W = 9;
    localparam int M_DATA_W = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_READ_LAST,
        ST_MOVE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* rtl/point_set_table_top.sv */
// Point set table: an unordered set of 2-D points in one memory with a linear search.
//
// Each request carries an opcode (insert, delete, search) and a point. The block scans the live
// entries of its point memory one per cycle through the single read port; a delete that hits
// also reads the last entry and moves it into the freed slot. One request is worked on at a
// time; a finished response waits in the output register while the next request is taken.
// No clearing pass is needed after reset.
`default_nettype none

module point_set_table_top
    import pst_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int COORD_WIDTH = 16,
    localparam int S_DATA_W   = ((OPCODE_W + 2 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // opcode, point_x, point_y
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // found, done_res, full_res, point_count
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int KEY_W     = 2 * COORD_WIDTH;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CNT_EXT_W = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;

    state_t state_reg, state_next;

    logic [KEY_W-1:0]  mem [CAPACITY];
    logic [KEY_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]       slot_reg, slot_next;
    logic                   hit_reg, hit_next;
    logic                   done_reg, done_next;
    logic                   full_reg, full_next;
    opcode_t                op_reg, op_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                   s_accept;
    logic                   issue;
    logic                   match;
    logic                   scan_end;
    logic                   out_free;
    logic [CNT_W-1:0]       last_idx;
    logic [CNT_EXT_W-1:0]   count_ext;

    assign s_accept = s_tvalid && s_tready;
    assign issue    = (scan_idx_reg < count_reg);
    assign match    = cmp_valid_reg && (rd_data_reg == key_reg);
    assign scan_end = !issue && !cmp_valid_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_idx = count_reg - CNT_W'(1);
    assign count_ext = CNT_EXT_W'(count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Point memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match || scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_DELETE && hit_reg)
                begin
                    state_next = ST_READ_LAST;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_READ_LAST: state_next = ST_MOVE;
            ST_MOVE:      state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        done_next      = done_reg;
        full_next      = full_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        rd_addr        = scan_idx_reg[ADDR_W-1:0];
        mem_we         = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next       = opcode_t'(s_tdata[OPCODE_W-1:0]);
                    key_next      = s_tdata[OPCODE_W +: KEY_W];
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    done_next     = 1'b0;
                    full_next     = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Address goes out this cycle; its entry is compared in the next one.
                cmp_valid_next = issue;
                cmp_idx_next   = scan_idx_reg;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_next  = 1'b1;
                    slot_next = cmp_idx_reg;
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_INSERT && !hit_reg)
                begin
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        done_next  = 1'b1;
                    end
                end
            end
            ST_READ_LAST:
            begin
                rd_addr = last_idx[ADDR_W-1:0];
            end
            ST_MOVE:
            begin
                // The last live entry fills the freed slot.
                mem_we     = 1'b1;
                wr_addr    = slot_reg[ADDR_W-1:0];
                wr_data    = rd_data_reg;
                count_next = last_idx;
                done_next  = 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_DATA_W - PCOUNT_W - 3)'(0), count_ext[PCOUNT_W-1:0],
                                     full_reg, done_reg, hit_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        done_reg     <= done_next;
        full_reg     <= full_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        m_tdata_reg  <= m_tdata_next;
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
    else $error("point count exceeds capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_DECIDE || state_reg == ST_MOVE))
    else $error("point memory written outside an update step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
    else $error("delete did not shrink the count by one");
`endif

endmodule

`default_nettype wire
